// ===== hw/rtl/wfeb_pkg.sv =====
// shared types and constants of the frame classifier
`timescale 1ns / 1ps

package wfeb_pkg;

   localparam int COUNT_W = 12;
   localparam int LEN_W = 11;
   localparam int ADDR_W = 48;
   localparam int CSR_INDEX_W = 2;
   localparam int QUEUE_DEPTH = 2;

   // frame control fields
   localparam logic [7:0] FC_TYPE_MASK = 8'h0c;
   localparam logic [7:0] FC_TYPE_DATA = 8'h08;
   localparam logic [7:0] FC_SUBTYPE_MASK = 8'hfc;
   localparam logic [7:0] FC_BEACON = 8'h80;
   localparam logic [7:0] FC_PROBE_RESP = 8'h50;

   // llc/snap header carrying eapol
   localparam logic [7:0] LLC_SAP = 8'haa;
   localparam logic [7:0] LLC_CTRL = 8'h03;
   localparam logic [7:0] ETHERTYPE_HI = 8'h88;
   localparam logic [7:0] ETHERTYPE_LO = 8'h8e;

   localparam logic [COUNT_W-1:0] FCS_LEN = 12'd4;
   localparam logic [COUNT_W-1:0] MIN_FRAME_LEN = 12'd24;
   localparam logic [COUNT_W-1:0] MIN_DATA_LEN = 12'd32;
   localparam logic [COUNT_W-1:0] MIN_WDS_LEN = 12'd34;
   localparam logic [5:0] HDR_LEN_3ADDR = 6'd24;
   localparam logic [5:0] HDR_LEN_4ADDR = 6'd30;
   localparam logic [5:0] QOS_CTRL_LEN = 6'd2;
   localparam logic [5:0] HTC_LEN = 6'd4;
   localparam logic [5:0] LLC_SNAP_LEN = 6'd8;

   // possible llc offsets: 24, 26, ... 36
   localparam int NUM_LLC_OFFSETS = 7;

   // address byte positions
   localparam logic [COUNT_W-1:0] POS_FC0 = 12'd0;
   localparam logic [COUNT_W-1:0] POS_FC1 = 12'd1;
   localparam logic [COUNT_W-1:0] POS_ADDR1 = 12'd4;
   localparam logic [COUNT_W-1:0] POS_ADDR2 = 12'd10;
   localparam logic [COUNT_W-1:0] POS_ADDR3 = 12'd16;
   localparam logic [COUNT_W-1:0] ADDR_BYTES = 12'd6;

   typedef enum logic [2:0] {
      VERDICT_TOO_SHORT = 3'd0,
      VERDICT_NOT_KEPT = 3'd1,
      VERDICT_BEACON = 3'd2,
      VERDICT_EAPOL = 3'd3,
      VERDICT_PIN_MISMATCH = 3'd4
   } verdict_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PIN_ENABLE = 2'd0,
      CSR_PIN_BSSID = 2'd1
   } csr_index_type;

   // summary of one frame handed from the byte front end to the verdict stage
   typedef struct packed {
      logic [COUNT_W-1:0] len;
      logic [7:0] fc0;
      logic [7:0] fc1;
      logic is_beacon;
      logic [NUM_LLC_OFFSETS-1:0] llc_match;
      logic [ADDR_W-1:0] bssid;
   } frame_info_type;

endpackage

// ===== hw/rtl/wlan_frame_eapol_beacon_classifier.sv =====
// top level of the 802.11 eapol and beacon frame classifier
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_data_byte, req_last_byte
//   rsp     | out       | rsp_valid / rsp_stall | rsp_verdict, rsp_bssid,
//           |           |                       | rsp_kept_length, rsp_truncated
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// one byte per cycle is taken unless req_stall is high; header fields and llc/snap hits
// are caught as bytes stream by; a result passes the queue write, then the result register
// req_stall rises only when both queue entries hold frames waiting on a stalled rsp side
// csr_ready is always high; registers are sampled when the verdict is formed
// reset is synchronous and clears byte count, queue and result valid
`timescale 1ns / 1ps

module wlan_frame_eapol_beacon_classifier
   import wfeb_pkg::*;
#(
   parameter int CAPTURE_LIMIT = 1400,
   parameter int MAX_FRAME_BYTES = 4095
) (
   input  logic clock,
   input  logic reset,
   // byte stream in
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_data_byte,
   input  logic req_last_byte,
   // verdict out
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [2:0] rsp_verdict,
   output logic [ADDR_W-1:0] rsp_bssid,
   output logic [LEN_W-1:0] rsp_kept_length,
   output logic rsp_truncated,
   // register writes
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0] csr_data
);

   localparam logic [LEN_W-1:0] CAP_KEPT = LEN_W'(CAPTURE_LIMIT);

   logic pin_enable_ff;
   logic [ADDR_W-1:0] pin_bssid_ff;
   logic byte_take;
   logic info_push, info_pop, q_full, q_not_empty;
   frame_info_type front_info, head_info;

   // configuration registers, written one transaction at a time
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_enable_ff <= 1'b0;
         pin_bssid_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PIN_ENABLE: pin_enable_ff <= csr_data[0];
            CSR_PIN_BSSID: pin_bssid_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // front end takes a byte whenever the queue has room
   assign req_stall = q_full;
   assign byte_take = req_valid && !req_stall;

   wfeb_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .byte_take(byte_take),
      .data_byte(req_data_byte),
      .last_byte(req_last_byte),
      .info_push(info_push),
      .info(front_info)
   );

   // decouples the byte stream from a stalled result side
   wfeb_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(info_push),
      .push_info(front_info),
      .full(q_full),
      .not_empty(q_not_empty),
      .pop(info_pop),
      .head_info(head_info)
   );

   wfeb_back #(
      .CAPTURE_LIMIT(CAPTURE_LIMIT)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .info_avail(q_not_empty),
      .info(head_info),
      .info_pop(info_pop),
      .pin_enable(pin_enable_ff),
      .pin_bssid(pin_bssid_ff),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_verdict(rsp_verdict),
      .rsp_bssid(rsp_bssid),
      .rsp_kept_length(rsp_kept_length),
      .rsp_truncated(rsp_truncated)
   );

`ifndef SYNTHESIS
   a_unkept_no_bssid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict == VERDICT_TOO_SHORT || rsp_verdict == VERDICT_NOT_KEPT)
      |-> rsp_bssid == '0) else $error("bssid reported for a frame not kept");
   a_trunc_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_truncated |-> rsp_kept_length == CAP_KEPT)
      else $error("truncated frame length not capped");
   a_short_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == VERDICT_TOO_SHORT |-> !rsp_truncated &&
      rsp_kept_length < LEN_W'(MIN_FRAME_LEN)) else $error("too short verdict on long frame");
   a_last_byte_queued: assert property (@(posedge clock) disable iff (reset)
      byte_take && req_last_byte |=> q_not_empty)
      else $error("final byte did not queue a frame");
`endif

endmodule

// ===== hw/rtl/wfeb_front.sv =====
// byte front end: counts bytes, captures header fields, spots llc/snap on the fly
`timescale 1ns / 1ps

module wfeb_front
   import wfeb_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 4095
) (
   input  logic clock,
   input  logic reset,
   input  logic byte_take,
   input  logic [7:0] data_byte,
   input  logic last_byte,
   output logic info_push,
   output frame_info_type info
);

   localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_FRAME_BYTES);

   logic [COUNT_W-1:0] cnt_ff, cnt_in, total;
   logic [7:0] fc0_ff, fc0_in, fc1_ff, fc1_in;
   logic [ADDR_W-1:0] a1_ff, a1_in, a2_ff, a2_in, a3_ff, a3_in;
   logic [7:0] win_ff [7];
   logic [NUM_LLC_OFFSETS-1:0] match_ff, match_in, match_now;
   logic llc_hit;
   logic [7:0] fc_subtype;
   logic to_ds, from_ds;

   // last seven bytes plus the current one form an llc/snap candidate
   assign llc_hit = (win_ff[6] == LLC_SAP) && (win_ff[5] == LLC_SAP) &&
                    (win_ff[4] == LLC_CTRL) && (win_ff[0] == ETHERTYPE_HI) &&
                    (data_byte == ETHERTYPE_LO);

   always_comb begin
      for (int k = 0; k < NUM_LLC_OFFSETS; k++) begin
         match_now[k] = match_ff[k] | (llc_hit &&
            (cnt_ff == COUNT_W'(int'(HDR_LEN_3ADDR) + 7 + 2 * k)));
      end
   end

   assign total = (cnt_ff < MAX_CNT) ? cnt_ff + 12'd1 : cnt_ff;

   always_comb begin
      cnt_in = last_byte ? '0 : total;
      match_in = last_byte ? '0 : match_now;
      fc0_in = (cnt_ff == POS_FC0) ? data_byte : fc0_ff;
      fc1_in = (cnt_ff == POS_FC1) ? data_byte : fc1_ff;
      a1_in = (cnt_ff >= POS_ADDR1 && cnt_ff < POS_ADDR1 + ADDR_BYTES) ?
              {a1_ff[ADDR_W-9:0], data_byte} : a1_ff;
      a2_in = (cnt_ff >= POS_ADDR2 && cnt_ff < POS_ADDR2 + ADDR_BYTES) ?
              {a2_ff[ADDR_W-9:0], data_byte} : a2_ff;
      a3_in = (cnt_ff >= POS_ADDR3 && cnt_ff < POS_ADDR3 + ADDR_BYTES) ?
              {a3_ff[ADDR_W-9:0], data_byte} : a3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         match_ff <= '0;
      end else if (byte_take) begin
         cnt_ff <= cnt_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_take) begin
         fc0_ff <= fc0_in;
         fc1_ff <= fc1_in;
         a1_ff <= a1_in;
         a2_ff <= a2_in;
         a3_ff <= a3_in;
         win_ff[0] <= data_byte;
         for (int i = 1; i < 7; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

   // frame summary, valid at the final byte
   assign fc_subtype = fc0_ff & FC_SUBTYPE_MASK;
   assign to_ds = fc1_ff[0];
   assign from_ds = fc1_ff[1];

   always_comb begin
      info.len = (total > FCS_LEN) ? total - FCS_LEN : total;
      info.fc0 = fc0_ff;
      info.fc1 = fc1_ff;
      info.is_beacon = (fc_subtype == FC_BEACON) || (fc_subtype == FC_PROBE_RESP);
      info.llc_match = match_now;
      if (!info.is_beacon && to_ds && !from_ds) begin
         info.bssid = a1_ff;
      end else if (!info.is_beacon && from_ds && !to_ds) begin
         info.bssid = a2_ff;
      end else begin
         info.bssid = a3_ff;
      end
   end

   assign info_push = byte_take & last_byte;

endmodule

// ===== hw/rtl/wfeb_queue.sv =====
// short queue of frame summaries between front end and verdict stage
`timescale 1ns / 1ps

module wfeb_queue
   import wfeb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  frame_info_type push_info,
   output logic full,
   output logic not_empty,
   input  logic pop,
   output frame_info_type head_info
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_info_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_info;
      end
   end

   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_info = mem_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("queue pop while empty");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> not_empty) else $error("queue lost an entry");
`endif

endmodule

// ===== hw/rtl/wfeb_back.sv =====
// verdict stage: frame type, eapol offset, pin filter, length cap, result register
`timescale 1ns / 1ps

module wfeb_back
   import wfeb_pkg::*;
#(
   parameter int CAPTURE_LIMIT = 1400
) (
   input  logic clock,
   input  logic reset,
   input  logic info_avail,
   input  frame_info_type info,
   output logic info_pop,
   input  logic pin_enable,
   input  logic [ADDR_W-1:0] pin_bssid,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [2:0] rsp_verdict,
   output logic [ADDR_W-1:0] rsp_bssid,
   output logic [LEN_W-1:0] rsp_kept_length,
   output logic rsp_truncated
);

   localparam logic [COUNT_W-1:0] CAP_LEN = COUNT_W'(CAPTURE_LIMIT);

   logic rsp_valid_ff, rsp_valid_in;
   verdict_type verdict_ff, verdict_in;
   logic [ADDR_W-1:0] bssid_ff, bssid_in;
   logic [LEN_W-1:0] kept_ff, kept_in;
   logic trunc_ff, trunc_in;

   logic [5:0] off_base, off_qos, off;
   logic [2:0] llc_idx;
   logic is_data, wds, eapol;
   logic [COUNT_W-1:0] len;

   assign len = info.len;
   assign is_data = (info.fc0 & FC_TYPE_MASK) == FC_TYPE_DATA;
   assign wds = info.fc1[0] & info.fc1[1];

   // payload offset: header length, qos control, then htc if it fits
   always_comb begin
      off_base = wds ? HDR_LEN_4ADDR : HDR_LEN_3ADDR;
      off_qos = info.fc0[7] ? off_base + QOS_CTRL_LEN : off_base;
      if (info.fc1[7] && ({6'd0, off_qos} + {6'd0, HTC_LEN} <= len)) begin
         off = off_qos + HTC_LEN;
      end else begin
         off = off_qos;
      end
      llc_idx = 3'((off - HDR_LEN_3ADDR) >> 1);
   end

   always_comb begin
      eapol = is_data && (len >= MIN_DATA_LEN) && (!wds || len >= MIN_WDS_LEN) &&
              ({6'd0, off} + {6'd0, LLC_SNAP_LEN} <= len) && info.llc_match[llc_idx];
   end

   assign info_pop = info_avail && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      trunc_in = len > CAP_LEN;
      kept_in = trunc_in ? CAP_LEN[LEN_W-1:0] : len[LEN_W-1:0];
      bssid_in = info.bssid;
      if (len < MIN_FRAME_LEN) begin
         verdict_in = VERDICT_TOO_SHORT;
         bssid_in = '0;
      end else if (info.is_beacon) begin
         verdict_in = VERDICT_BEACON;
      end else if (eapol) begin
         verdict_in = VERDICT_EAPOL;
      end else begin
         verdict_in = VERDICT_NOT_KEPT;
         bssid_in = '0;
      end
      if ((verdict_in == VERDICT_BEACON || verdict_in == VERDICT_EAPOL) &&
          pin_enable && info.bssid != pin_bssid) begin
         verdict_in = VERDICT_PIN_MISMATCH;
      end
      if (info_pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (info_pop) begin
         verdict_ff <= verdict_in;
         bssid_ff <= bssid_in;
         kept_ff <= kept_in;
         trunc_ff <= trunc_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;
   assign rsp_bssid = bssid_ff;
   assign rsp_kept_length = kept_ff;
   assign rsp_truncated = trunc_ff;

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for the 802.11 eapol and beacon frame classifier
`timescale 1ns / 1ps

module testbench;
   import wfeb_pkg::*;

   localparam int CAPTURE_CAP = 1400;
   localparam int FRAME_CAP = 4095;
   localparam int HDR_WINDOW = 44;
   localparam int SETTLE_CYCLES = 8;     // quiet wait once every verdict is back
   localparam int HOLD_CYCLES = 300;     // one long receiver hold-off
   localparam longint TIMEOUT_NS = 2_000_000;

   // frame control bits that steer the eapol search
   localparam logic [7:0] FC0_QOS = 8'h80;
   localparam logic [7:0] FC1_TO_DS = 8'h01;
   localparam logic [7:0] FC1_FROM_DS = 8'h02;
   localparam logic [7:0] FC1_ORDER = 8'h80;
   localparam logic [7:0] FC_PROBE_REQ = 8'h40;

   typedef struct packed {
      logic [7:0] data;
      logic last;
   } byte_item;

   typedef struct {
      verdict_type verdict;
      logic [ADDR_W-1:0] bssid;
      logic [LEN_W-1:0] kept_length;
      logic truncated;
   } verdict_rec;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_data_byte = '0;
   logic req_last_byte = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_verdict;
   logic [ADDR_W-1:0] rsp_bssid;
   logic [LEN_W-1:0] rsp_kept_length;
   logic rsp_truncated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [ADDR_W-1:0] csr_data = '0;

   // stimulus and scoreboard state
   byte_item pending_bytes[$];
   byte_item next_byte;
   verdict_rec expected_verdicts[$];
   logic [7:0] frame_image[$];
   int bytes_queued = 0;
   int bytes_taken = 0;
   int frames_queued = 0;
   int verdicts_seen = 0;
   int mismatches = 0;
   int held_cycles = 0;
   int verdict_tally[5] = '{default: 0};

   // idling control: calm turns off random gaps on both sides
   logic calm = 1'b0;
   logic hold_request = 1'b0;
   logic hold_done = 1'b0;
   int hold_left = 0;

   // mirrored block state for the predictor
   logic pin_on = 1'b0;
   logic [ADDR_W-1:0] pin_addr = '0;
   logic [COUNT_W-1:0] rx_count = '0;
   logic [7:0] hdr_seen[HDR_WINDOW];

   wlan_frame_eapol_beacon_classifier #(
      .CAPTURE_LIMIT(CAPTURE_CAP),
      .MAX_FRAME_BYTES(FRAME_CAP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_verdict(rsp_verdict),
      .rsp_bssid(rsp_bssid),
      .rsp_kept_length(rsp_kept_length),
      .rsp_truncated(rsp_truncated),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   // six header bytes starting at pos, first byte most significant
   function automatic logic [ADDR_W-1:0] addr_from(input int pos);
      logic [ADDR_W-1:0] a;
      a = '0;
      for (int i = 0; i < 6; i++) begin
         a = {a[ADDR_W-9:0], hdr_seen[pos + i]};
      end
      return a;
   endfunction

   // verdict for a frame of total bytes (fcs included, already saturated)
   function automatic verdict_rec classify_frame(input int total);
      verdict_rec r;
      int len;
      int off;
      int bpos;
      logic [7:0] fc0;
      logic [7:0] fc1;
      logic [7:0] subtype;
      bit keep;
      len = (total > 4) ? total - 4 : total;
      fc0 = hdr_seen[0];
      fc1 = hdr_seen[1];
      r.bssid = '0;
      keep = 1'b0;
      if (len < 24) begin
         r.verdict = VERDICT_TOO_SHORT;
      end else begin
         subtype = fc0 & FC_SUBTYPE_MASK;
         if (subtype == FC_BEACON || subtype == FC_PROBE_RESP) begin
            // beacon or probe response: bssid is address 3
            r.bssid = addr_from(16);
            keep = 1'b1;
         end else if (len >= 32 && (fc0 & FC_TYPE_MASK) == FC_TYPE_DATA &&
                      (fc1[1:0] != 2'b11 || len >= 34)) begin
            // data frame: header length and bssid slot follow the ds bits
            off = (fc1[1:0] == 2'b11) ? 30 : 24;
            case (fc1[1:0])
               2'b01: bpos = 4;
               2'b10: bpos = 10;
               default: bpos = 16;
            endcase
            if ((fc0 & FC0_QOS) != 0) off += 2;
            if ((fc1 & FC1_ORDER) != 0 && off + 4 <= len) off += 4;
            if (off + 8 <= len && hdr_seen[off] == LLC_SAP && hdr_seen[off + 1] == LLC_SAP &&
                hdr_seen[off + 2] == LLC_CTRL && hdr_seen[off + 6] == ETHERTYPE_HI &&
                hdr_seen[off + 7] == ETHERTYPE_LO) begin
               r.bssid = addr_from(bpos);
               keep = 1'b1;
            end
         end
         if (!keep) begin
            r.verdict = VERDICT_NOT_KEPT;
         end else if (pin_on && r.bssid != pin_addr) begin
            r.verdict = VERDICT_PIN_MISMATCH;
         end else begin
            r.verdict = (subtype == FC_BEACON || subtype == FC_PROBE_RESP) ?
                        VERDICT_BEACON : VERDICT_EAPOL;
         end
      end
      r.truncated = (len > CAPTURE_CAP);
      r.kept_length = r.truncated ? LEN_W'(CAPTURE_CAP) : LEN_W'(len);
      return r;
   endfunction

   // one accepted byte; the marked last byte closes the frame
   task automatic take_byte(input logic [7:0] b, input logic last);
      if (rx_count < HDR_WINDOW) hdr_seen[rx_count] = b;
      if (rx_count < FRAME_CAP) rx_count++;
      if (last) begin
         expected_verdicts.push_back(classify_frame(int'(rx_count)));
         rx_count = '0;
      end
   endtask

   // ---------------------------------------------------------------
   // driver: byte stream from the pending queue
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_stall) held_cycles++;
         if (req_valid && !req_stall) begin
            take_byte(req_data_byte, req_last_byte);
            bytes_taken++;
         end
         // a stalled transaction keeps its payload
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
               next_byte = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= next_byte.data;
               req_last_byte <= next_byte.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: verdict checks and receiver stalls
   // ---------------------------------------------------------------
   task automatic report_field(input string field, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
      $display("%0t: %s differs, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
   endtask

   task automatic check_verdict();
      verdict_rec want;
      verdicts_seen++;
      if (rsp_verdict < 5) verdict_tally[rsp_verdict]++;
      if (expected_verdicts.size() == 0) begin
         $display("%0t: verdict %0d arrived with no frame outstanding", $time, rsp_verdict);
         mismatches++;
      end else begin
         want = expected_verdicts.pop_front();
         if (rsp_verdict !== want.verdict) report_field("verdict", want.verdict, rsp_verdict);
         if (rsp_bssid !== want.bssid) report_field("bssid", want.bssid, rsp_bssid);
         if (rsp_kept_length !== want.kept_length)
            report_field("kept_length", want.kept_length, rsp_kept_length);
         if (rsp_truncated !== want.truncated)
            report_field("truncated", want.truncated, rsp_truncated);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_verdict();
         // one long hold-off lets the result queue fill and back up the input
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 15);
         end
      end
   end

   // ---------------------------------------------------------------
   // frame builders
   // ---------------------------------------------------------------
   function automatic logic [ADDR_W-1:0] rand_addr();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // addresses that hit or just miss the pin, all zeros, all ones or random
   function automatic logic [ADDR_W-1:0] pick_bssid();
      case ($urandom_range(4))
         0: return pin_addr;
         1: return '0;
         2: return '1;
         3: return pin_addr ^ (48'd1 << $urandom_range(ADDR_W - 1));
         default: return rand_addr();
      endcase
   endfunction

   task automatic push_random(input int n);
      repeat (n) frame_image.push_back(8'($urandom));
   endtask

   task automatic push_addr(input logic [ADDR_W-1:0] a);
      for (int i = 5; i >= 0; i--) frame_image.push_back(a[i*8 +: 8]);
   endtask

   // data frame carrying llc/snap, optionally with one checked byte spoiled
   task automatic build_data(input logic [7:0] fc0, input logic [7:0] fc1,
                             input logic [ADDR_W-1:0] bss, input int body_len,
                             input bit snap_ok);
      int bpos;
      int llc_at;
      int bad;
      frame_image = {};
      frame_image.push_back(fc0);
      frame_image.push_back(fc1);
      push_random(2);
      case (fc1[1:0])
         2'b01: bpos = 4;
         2'b10: bpos = 10;
         default: bpos = 16;
      endcase
      for (int p = 4; p <= 16; p += 6) push_addr((p == bpos) ? bss : rand_addr());
      push_random(2);                              // sequence control
      if (fc1[1:0] == 2'b11) push_addr(rand_addr());   // address 4
      if ((fc0 & FC0_QOS) != 0) push_random(2);
      if ((fc1 & FC1_ORDER) != 0) push_random(4);
      llc_at = frame_image.size();
      frame_image.push_back(LLC_SAP);
      frame_image.push_back(LLC_SAP);
      frame_image.push_back(LLC_CTRL);
      push_random(3);
      frame_image.push_back(ETHERTYPE_HI);
      frame_image.push_back(ETHERTYPE_LO);
      if (!snap_ok) begin
         case ($urandom_range(4))
            0: bad = 0;
            1: bad = 1;
            2: bad = 2;
            3: bad = 6;
            default: bad = 7;
         endcase
         frame_image[llc_at + bad] = frame_image[llc_at + bad] ^ 8'($urandom_range(1, 255));
      end
      push_random(body_len + 4);                   // body and fcs
   endtask

   // management frame with bssid in address 3
   task automatic build_mgmt(input logic [7:0] fc0, input logic [ADDR_W-1:0] bss,
                             input int body_len);
      frame_image = {};
      frame_image.push_back(fc0);
      push_random(3);
      push_addr(rand_addr());
      push_addr(rand_addr());
      push_addr(bss);
      push_random(2 + body_len + 4);
   endtask

   task automatic build_noise(input int n);
      frame_image = {};
      push_random(n);
   endtask

   task automatic send_frame();
      byte_item it;
      foreach (frame_image[i]) begin
         it.data = frame_image[i];
         it.last = (i == frame_image.size() - 1);
         pending_bytes.push_back(it);
      end
      bytes_queued += frame_image.size();
      frames_queued++;
   endtask

   // wait until every byte is taken and every verdict is back
   task automatic drain();
      while (bytes_taken != bytes_queued || expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [ADDR_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_PIN_ENABLE) pin_on = value[0];
      else pin_addr = value;
   endtask

   task automatic run_random_phase(input int min_frames, input int min_bytes);
      int start_frames;
      int start_bytes;
      int pick;
      start_frames = frames_queued;
      start_bytes = bytes_queued;
      while (frames_queued - start_frames < min_frames ||
             bytes_queued - start_bytes < min_bytes) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            // well-formed eapol with random header options
            build_data((8'($urandom) & ~FC_TYPE_MASK) | FC_TYPE_DATA, 8'($urandom),
                       pick_bssid(), $urandom_range(20), 1'b1);
         end else if (pick < 68) begin
            build_mgmt(($urandom_range(1) ? FC_BEACON : FC_PROBE_RESP) | 8'($urandom_range(3)),
                       pick_bssid(), $urandom_range(20));
         end else if (pick < 70) begin
            // occasional beacon with a longer body
            build_mgmt(FC_BEACON, pick_bssid(), $urandom_range(40, 120));
         end else if (pick < 80) begin
            // broken eapol: spoiled snap or cut short
            build_data((8'($urandom) & ~FC_TYPE_MASK) | FC_TYPE_DATA, 8'($urandom),
                       pick_bssid(), $urandom_range(4), $urandom_range(1));
            repeat ($urandom_range(1, 12)) void'(frame_image.pop_back());
         end else begin
            build_noise($urandom_range(1, 48));
            if ($urandom_range(1)) frame_image[0] = (frame_image[0] & ~FC_TYPE_MASK) | FC_TYPE_DATA;
         end
         send_frame();
      end
      drain();
   endtask

   // ---------------------------------------------------------------
   // sequence of phases
   // ---------------------------------------------------------------
   initial begin
      logic [ADDR_W-1:0] home;
      home = 48'h0200_5e10_2a3c;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // pin off: length boundaries and every frame kind
      write_csr(CSR_PIN_ENABLE, '0);
      write_csr(CSR_PIN_BSSID, '0);
      frame_image = {8'h00};                        // lone last byte
      send_frame();
      frame_image = {8'hff, 8'hff, 8'hff, 8'hff};   // no fcs strip
      send_frame();
      build_noise(5);
      send_frame();
      build_noise(27);                              // one byte short of a header
      frame_image[0] = FC_BEACON;
      send_frame();
      build_mgmt(FC_BEACON, '0, 0);                 // bare 24-byte header
      send_frame();
      build_mgmt(FC_PROBE_RESP | 8'h03, '1, 10);
      send_frame();
      build_mgmt(FC_PROBE_REQ, home, 6);
      send_frame();
      build_data(FC_TYPE_DATA, 8'h00, home, 0, 1'b1);
      send_frame();
      build_data(FC_TYPE_DATA, FC1_TO_DS, home, 3, 1'b1);
      send_frame();
      build_data(FC_TYPE_DATA, FC1_FROM_DS, '1, 0, 1'b1);
      send_frame();
      // four addresses, qos and htc: deepest llc offset
      build_data(FC_TYPE_DATA | FC0_QOS, FC1_TO_DS | FC1_FROM_DS | FC1_ORDER, home, 5, 1'b1);
      send_frame();
      build_data(FC_TYPE_DATA | FC0_QOS, FC1_TO_DS | FC1_FROM_DS, home, 0, 1'b0);
      send_frame();
      build_data(FC_TYPE_DATA, 8'h00, home, 0, 1'b1);
      void'(frame_image.pop_back());                // llc runs past the frame end
      send_frame();
      drain();

      // pin on: matching and non-matching bssid for both kept kinds
      write_csr(CSR_PIN_BSSID, home);
      write_csr(CSR_PIN_ENABLE, 48'd1);
      build_mgmt(FC_BEACON, home, 4);
      send_frame();
      build_mgmt(FC_BEACON, ~home, 4);
      send_frame();
      build_data(FC_TYPE_DATA, FC1_TO_DS, home, 2, 1'b1);
      send_frame();
      build_data(FC_TYPE_DATA | FC0_QOS, FC1_FROM_DS | FC1_ORDER, rand_addr(), 2, 1'b1);
      send_frame();
      build_data(FC_TYPE_DATA, 8'h00, home, 2, 1'b0);
      send_frame();
      build_noise(9);
      send_frame();
      drain();

      // random phases under varied pin settings
      write_csr(CSR_PIN_BSSID, '1);
      run_random_phase(4, 150);

      write_csr(CSR_PIN_ENABLE, '0);
      calm <= 1'b1;                                 // no gaps on either side
      run_random_phase(4, 150);
      calm <= 1'b0;

      write_csr(CSR_PIN_ENABLE, 48'd1);
      write_csr(CSR_PIN_BSSID, '0);
      hold_request <= 1'b1;                         // receiver holds off early in this phase
      run_random_phase(4, 150);

      write_csr(CSR_PIN_BSSID, rand_addr());
      run_random_phase(4, 150);

      $display("covered %0d frames in %0d bytes; input held back for %0d cycles",
               frames_queued, bytes_queued, held_cycles);
      $display("verdicts: short %0d, not kept %0d, beacon %0d, eapol %0d, pin miss %0d",
               verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
               verdict_tally[4]);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("timeout: %0d frame verdicts still outstanding", expected_verdicts.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
